// File: hdl/sbpc_pkg.sv
`timescale 1ns / 1ps

package sbpc_pkg;

   localparam int MISMATCH_COST_DEF = 1000;

   localparam int DIV_NUM_W = 64;
   localparam int DIV_DEN_W = 48;
   localparam int DIV_CNT_W = 7;

   localparam logic [2:0] REG_Y_OFFSET    = 3'd0;
   localparam logic [2:0] REG_WEIGHT_X    = 3'd1;
   localparam logic [2:0] REG_WEIGHT_Y    = 3'd2;
   localparam logic [2:0] REG_WEIGHT_SIZE = 3'd3;
   localparam logic [2:0] REG_LIMIT_X     = 3'd4;
   localparam logic [2:0] REG_LIMIT_Y     = 3'd5;
   localparam logic [2:0] REG_LIMIT_SIZE  = 3'd6;
   localparam logic [2:0] REG_PENALTY     = 3'd7;

   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_COMPARE = 1'b1;

   typedef struct packed {
      logic                 start;
      logic [DIV_CNT_W-1:0] count;
   } div_ctl_type;

   // cos(k*pi/32) in q16
   function automatic logic [16:0] cos_lut(input logic [4:0] idx);
      logic [16:0] v;
      case (idx)
         5'd0:    v = 17'd65536;
         5'd1:    v = 17'd65220;
         5'd2:    v = 17'd64277;
         5'd3:    v = 17'd62714;
         5'd4:    v = 17'd60547;
         5'd5:    v = 17'd57798;
         5'd6:    v = 17'd54491;
         5'd7:    v = 17'd50660;
         5'd8:    v = 17'd46341;
         5'd9:    v = 17'd41576;
         5'd10:   v = 17'd36410;
         5'd11:   v = 17'd30893;
         5'd12:   v = 17'd25080;
         5'd13:   v = 17'd19024;
         5'd14:   v = 17'd12785;
         5'd15:   v = 17'd6424;
         default: v = 17'd0;
      endcase
      return v;
   endfunction

endpackage

// File: hdl/stereo_box_pair_cost_core.sv
`timescale 1ns / 1ps

// Stereo box pair cost: one row of a stereo matching cost matrix.
// Request channel (req_valid / req_stall): op 0 loads the left box of the row
// without leaving idle, giving no response. Op 1 compares one right box with
// the stored left box and gives one response on rsp_valid / rsp_stall with
// the Q16.16 pair cost and the column.
// A compare keeps the core busy until its response is registered, and the
// next request is taken once it is idle again: one shared multiplier runs the area,
// geometry and weighting products one per cycle, and one bit-serial
// divider produces the y part (37 steps), the x ramp position (29 steps) and
// the two size divisions (64 steps each). Parts that fall out of range skip
// their division, so many compares finish sooner.
// req_stall is high while a compare is in progress. The response sits in an
// output register; while rsp_stall holds it, a new request can still be taken
// and worked on, and its response waits until the register frees.
// Configuration (csr_write, csr_index, csr_wdata) must be written by the user while idle; the core does not enforce it.
// Reset (synchronous) restores the register defaults and the empty row:
// frame -1, so a compare before any load costs at least the frame mismatch.
module stereo_box_pair_cost_core #(
   parameter int MISMATCH_COST = sbpc_pkg::MISMATCH_COST_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_op,
   input  logic signed [15:0] req_frame_index,
   input  logic [7:0]        req_class_label,
   input  logic [11:0]       req_box_left,
   input  logic [11:0]       req_box_top,
   input  logic [11:0]       req_box_width,
   input  logic [11:0]       req_box_height,
   input  logic signed [6:0] req_prior_column,
   input  logic [5:0]        req_column,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [31:0]       rsp_pair_cost,
   output logic [5:0]        rsp_out_column,
   input  logic              csr_write,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_wdata
);
   import sbpc_pkg::*;

   localparam logic [31:0] COST_CM = 32'(MISMATCH_COST) << 16;

   typedef enum logic [4:0] {
      S_IDLE, S_AREA_L, S_AREA_R, S_GEO1, S_GEO2, S_NUM, S_DEN, S_YMUL,
      S_YDIV, S_YWAIT, S_XDIV, S_XWAIT, S_XINT, S_XMUL, S_SDIV, S_SWAIT1,
      S_SMUL, S_SMUL2, S_SDIV2, S_SWAIT2, S_SUM, S_PEN
   } state_type;

   state_type state_ff, state_in;

   logic signed [12:0] y_offset_ff, y_offset_in;
   logic [15:0] weight_x_ff, weight_x_in;
   logic [15:0] weight_y_ff, weight_y_in;
   logic [15:0] weight_size_ff, weight_size_in;
   logic [11:0] limit_x_ff, limit_x_in;
   logic [11:0] limit_y_ff, limit_y_in;
   logic [15:0] limit_size_ff, limit_size_in;
   logic [15:0] penalty_ff, penalty_in;

   logic [15:0] row_frame_ff, row_frame_in;
   logic [7:0]  row_label_ff, row_label_in;
   logic [13:0] row_cx2_ff, row_cx2_in;
   logic [13:0] row_cy2_ff, row_cy2_in;
   logic [11:0] row_width_ff, row_width_in;
   logic [11:0] row_height_ff, row_height_in;
   logic [6:0]  row_prior_ff, row_prior_in;

   logic [15:0] cur_frame_ff, cur_frame_in;
   logic [7:0]  cur_label_ff, cur_label_in;
   logic [13:0] cur_cx2_ff, cur_cx2_in;
   logic [13:0] cur_cy2_ff, cur_cy2_in;
   logic [11:0] cur_width_ff, cur_width_in;
   logic [11:0] cur_height_ff, cur_height_in;
   logic [5:0]  cur_col_ff, cur_col_in;

   logic [23:0] area_l_ff, area_l_in;
   logic [23:0] area_r_ff, area_r_in;
   logic [23:0] geo1_ff, geo1_in;
   logic [23:0] geo2_ff, geo2_in;
   logic [47:0] num_ff, num_in;
   logic [47:0] den_ff, den_in;
   logic [28:0] ymul_ff, ymul_in;
   logic [15:0] pos_ff, pos_in;
   logic [16:0] cosv_ff, cosv_in;
   logic [48:0] ratio_ff, ratio_in;
   logic [63:0] sprod_ff, sprod_in;
   logic [31:0] x_part_ff, x_part_in;
   logic [31:0] y_part_ff, y_part_in;
   logic [31:0] s_part_ff, s_part_in;
   logic [31:0] total_ff, total_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_cost_ff, rsp_cost_in;
   logic [5:0]  rsp_col_ff, rsp_col_in;

   logic [31:0] mul_a;
   logic [23:0] mul_b;
   logic [55:0] prod;

   div_ctl_type          div_ctl;
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_DEN_W-1:0] div_den;
   logic [DIV_NUM_W-1:0] div_quo;
   logic                 div_done;

   logic signed [14:0] dx;
   logic signed [15:0] dy;
   logic [15:0] gy;
   logic [12:0] lim_x2, lim_y2;
   logic        y_bad, size_bad, pen_apply, out_free;
   logic [11:0] max1_rw, max1_rh, max1_cw, max1_ch;
   logic [16:0] cos_hi, cos_lo;
   logic [34:0] sum;
   logic [39:0] pen_shift;

   sbpc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (div_num),
      .divisor  (div_den),
      .quotient (div_quo),
      .done     (div_done)
   );

   assign prod = mul_a * mul_b;

   always_comb begin
      dx = $signed({1'b0, row_cx2_ff}) - $signed({1'b0, cur_cx2_ff});
      dy = $signed({2'b00, row_cy2_ff}) - $signed({2'b00, cur_cy2_ff})
           + $signed({{2{y_offset_ff[12]}}, y_offset_ff, 1'b0});
      gy = dy[15] ? 16'(-dy) : 16'(dy);
      lim_x2 = {limit_x_ff, 1'b0};
      lim_y2 = {limit_y_ff, 1'b0};
      y_bad = (weight_y_ff == 16'd0) || (gy >= {3'b000, lim_y2});
      size_bad = (area_l_ff == '0) || (area_r_ff == '0) || (limit_size_ff <= 16'd256);
      pen_apply = (row_prior_ff != 7'h7F) && (row_prior_ff != {1'b0, cur_col_ff});
      out_free = !rsp_valid_ff || !rsp_stall;
      max1_rw = (row_width_ff  == '0) ? 12'd1 : row_width_ff;
      max1_rh = (row_height_ff == '0) ? 12'd1 : row_height_ff;
      max1_cw = (cur_width_ff  == '0) ? 12'd1 : cur_width_ff;
      max1_ch = (cur_height_ff == '0) ? 12'd1 : cur_height_ff;
      cos_hi = cos_lut({1'b0, pos_ff[15:12]});
      cos_lo = cos_lut({1'b0, pos_ff[15:12]} + 5'd1);
      sum = 35'(x_part_ff) + 35'(y_part_ff) + 35'(s_part_ff)
            + (((row_frame_ff == cur_frame_ff) && ($signed(row_frame_ff) > 16'sd0))
               ? 35'd0 : 35'(COST_CM))
            + ((row_label_ff == cur_label_ff) ? 35'd0 : 35'(COST_CM));
      pen_shift = prod[47:8];

      // operand select for the shared multiplier
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_AREA_L: begin mul_a = 32'(row_width_ff); mul_b = 24'(row_height_ff); end
         S_AREA_R: begin mul_a = 32'(cur_width_ff); mul_b = 24'(cur_height_ff); end
         S_GEO1:   begin mul_a = 32'(max1_rh);      mul_b = 24'(max1_cw);       end
         S_GEO2:   begin mul_a = 32'(max1_rw);      mul_b = 24'(max1_ch);       end
         S_NUM: begin
            mul_a = 32'((area_l_ff > area_r_ff) ? area_l_ff : area_r_ff);
            mul_b = (geo1_ff > geo2_ff) ? geo1_ff : geo2_ff;
         end
         S_DEN: begin
            mul_a = 32'((area_l_ff < area_r_ff) ? area_l_ff : area_r_ff);
            mul_b = (geo1_ff < geo2_ff) ? geo1_ff : geo2_ff;
         end
         S_YMUL:  begin mul_a = 32'(weight_y_ff);       mul_b = 24'(gy);            end
         S_XINT:  begin mul_a = 32'(cos_hi - cos_lo);   mul_b = 24'(pos_ff[11:0]);  end
         S_XMUL:  begin mul_a = 32'(cosv_ff);           mul_b = 24'(weight_x_ff);   end
         // ratio times weight in two halves: low 32 bits, then the upper bits
         S_SMUL:  begin mul_a = ratio_ff[31:0];         mul_b = 24'(weight_size_ff); end
         S_SMUL2: begin mul_a = 32'(ratio_ff[48:32]);   mul_b = 24'(weight_size_ff); end
         S_PEN:   begin mul_a = total_ff;               mul_b = 24'(penalty_ff);    end
         default: begin mul_a = '0;                     mul_b = '0;                 end
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      y_offset_in    = y_offset_ff;
      weight_x_in    = weight_x_ff;
      weight_y_in    = weight_y_ff;
      weight_size_in = weight_size_ff;
      limit_x_in     = limit_x_ff;
      limit_y_in     = limit_y_ff;
      limit_size_in  = limit_size_ff;
      penalty_in     = penalty_ff;
      row_frame_in   = row_frame_ff;
      row_label_in   = row_label_ff;
      row_cx2_in     = row_cx2_ff;
      row_cy2_in     = row_cy2_ff;
      row_width_in   = row_width_ff;
      row_height_in  = row_height_ff;
      row_prior_in   = row_prior_ff;
      cur_frame_in   = cur_frame_ff;
      cur_label_in   = cur_label_ff;
      cur_cx2_in     = cur_cx2_ff;
      cur_cy2_in     = cur_cy2_ff;
      cur_width_in   = cur_width_ff;
      cur_height_in  = cur_height_ff;
      cur_col_in     = cur_col_ff;
      area_l_in      = area_l_ff;
      area_r_in      = area_r_ff;
      geo1_in        = geo1_ff;
      geo2_in        = geo2_ff;
      num_in         = num_ff;
      den_in         = den_ff;
      ymul_in        = ymul_ff;
      pos_in         = pos_ff;
      cosv_in        = cosv_ff;
      ratio_in       = ratio_ff;
      sprod_in       = sprod_ff;
      x_part_in      = x_part_ff;
      y_part_in      = y_part_ff;
      s_part_in      = s_part_ff;
      total_in       = total_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_cost_in    = rsp_cost_ff;
      rsp_col_in     = rsp_col_ff;
      div_ctl        = '0;
      div_num        = '0;
      div_den        = '0;

      if (csr_write) begin
         unique case (csr_index)
            REG_Y_OFFSET:    y_offset_in    = $signed(csr_wdata[12:0]);
            REG_WEIGHT_X:    weight_x_in    = csr_wdata;
            REG_WEIGHT_Y:    weight_y_in    = csr_wdata;
            REG_WEIGHT_SIZE: weight_size_in = csr_wdata;
            REG_LIMIT_X:     limit_x_in     = csr_wdata[11:0];
            REG_LIMIT_Y:     limit_y_in     = csr_wdata[11:0];
            REG_LIMIT_SIZE:  limit_size_in  = csr_wdata;
            REG_PENALTY:     penalty_in     = csr_wdata;
            default:         penalty_in     = penalty_ff;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_op == OP_LOAD) begin
                  row_frame_in  = req_frame_index;
                  row_label_in  = req_class_label;
                  row_cx2_in    = 14'({req_box_left, 1'b0}) + 14'(req_box_width);
                  row_cy2_in    = 14'({req_box_top, 1'b0}) + 14'(req_box_height);
                  row_width_in  = req_box_width;
                  row_height_in = req_box_height;
                  row_prior_in  = req_prior_column;
               end else begin
                  cur_frame_in  = req_frame_index;
                  cur_label_in  = req_class_label;
                  cur_cx2_in    = 14'({req_box_left, 1'b0}) + 14'(req_box_width);
                  cur_cy2_in    = 14'({req_box_top, 1'b0}) + 14'(req_box_height);
                  cur_width_in  = req_box_width;
                  cur_height_in = req_box_height;
                  cur_col_in    = req_column;
                  state_in      = S_AREA_L;
               end
            end
         end
         S_AREA_L: begin area_l_in = prod[23:0]; state_in = S_AREA_R; end
         S_AREA_R: begin area_r_in = prod[23:0]; state_in = S_GEO1;   end
         S_GEO1:   begin geo1_in   = prod[23:0]; state_in = S_GEO2;   end
         S_GEO2:   begin geo2_in   = prod[23:0]; state_in = S_NUM;    end
         S_NUM:    begin num_in    = prod[47:0]; state_in = S_DEN;    end
         S_DEN:    begin den_in    = prod[47:0]; state_in = S_YMUL;   end
         S_YMUL:   begin ymul_in   = prod[28:0]; state_in = S_YDIV;   end
         S_YDIV: begin
            if (y_bad) begin
               y_part_in = COST_CM;
               state_in  = S_XDIV;
            end else begin
               div_ctl.start = 1'b1;
               div_ctl.count = DIV_CNT_W'(37);
               div_num       = {ymul_ff, 8'd0, 27'd0};
               div_den       = DIV_DEN_W'(lim_y2);
               state_in      = S_YWAIT;
            end
         end
         S_YWAIT: begin
            if (div_done) begin
               y_part_in = 32'(div_quo[23:0]);
               state_in  = S_XDIV;
            end
         end
         S_XDIV: begin
            state_in = S_SDIV;
            if (dx[14]) begin
               x_part_in = COST_CM;
            end else if (limit_x_ff == '0) begin
               x_part_in = 32'({weight_x_ff, 8'd0});
            end else if (15'(dx) >= {2'b00, lim_x2}) begin
               x_part_in = '0;
            end else begin
               div_ctl.start = 1'b1;
               div_ctl.count = DIV_CNT_W'(29);
               div_num       = {dx[12:0], 16'd0, 35'd0};
               div_den       = DIV_DEN_W'(lim_x2);
               state_in      = S_XWAIT;
            end
         end
         S_XWAIT: begin
            if (div_done) begin
               pos_in   = div_quo[15:0];
               state_in = S_XINT;
            end
         end
         S_XINT: begin
            // truncating linear interpolation between table points
            cosv_in  = cos_hi - 17'(prod[28:12]);
            state_in = S_XMUL;
         end
         S_XMUL: begin
            x_part_in = 32'(prod[32:8]);
            state_in  = S_SDIV;
         end
         S_SDIV: begin
            if (size_bad) begin
               s_part_in = COST_CM;
               state_in  = S_SUM;
            end else begin
               div_ctl.start = 1'b1;
               div_ctl.count = DIV_CNT_W'(64);
               div_num       = {num_ff - den_ff, 16'd0};
               div_den       = den_ff;
               state_in      = S_SWAIT1;
            end
         end
         S_SWAIT1: begin
            if (div_done) begin
               ratio_in = (div_quo[63:48] != '0) ? {1'b1, 48'd0} : {1'b0, div_quo[47:0]};
               state_in = S_SMUL;
            end
         end
         S_SMUL: begin
            sprod_in = 64'(prod[47:0]);
            state_in = S_SMUL2;
         end
         S_SMUL2: begin
            // the ratio is at most 2^48, so the upper product stays within 32 bits
            sprod_in = sprod_ff + {prod[31:0], 32'd0};
            state_in = S_SDIV2;
         end
         S_SDIV2: begin
            div_ctl.start = 1'b1;
            div_ctl.count = DIV_CNT_W'(64);
            div_num       = sprod_ff;
            div_den       = DIV_DEN_W'(limit_size_ff - 16'd256);
            state_in      = S_SWAIT2;
         end
         S_SWAIT2: begin
            if (div_done) begin
               s_part_in = (div_quo[63:32] != '0) ? '1 : div_quo[31:0];
               state_in  = S_SUM;
            end
         end
         S_SUM: begin
            total_in = (sum[34:32] != '0) ? '1 : sum[31:0];
            state_in = S_PEN;
         end
         S_PEN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_col_in   = cur_col_ff;
               if (pen_apply) begin
                  rsp_cost_in = (pen_shift[39:32] != '0) ? '1 : pen_shift[31:0];
               end else begin
                  rsp_cost_in = total_ff;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         y_offset_ff    <= '0;
         weight_x_ff    <= 16'd256;
         weight_y_ff    <= 16'd256;
         weight_size_ff <= 16'd256;
         limit_x_ff     <= 12'd256;
         limit_y_ff     <= 12'd16;
         limit_size_ff  <= 16'd512;
         penalty_ff     <= 16'd512;
         row_frame_ff   <= '1;
         row_label_ff   <= '0;
         row_cx2_ff     <= '0;
         row_cy2_ff     <= '0;
         row_width_ff   <= '0;
         row_height_ff  <= '0;
         row_prior_ff   <= '1;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         y_offset_ff    <= y_offset_in;
         weight_x_ff    <= weight_x_in;
         weight_y_ff    <= weight_y_in;
         weight_size_ff <= weight_size_in;
         limit_x_ff     <= limit_x_in;
         limit_y_ff     <= limit_y_in;
         limit_size_ff  <= limit_size_in;
         penalty_ff     <= penalty_in;
         row_frame_ff   <= row_frame_in;
         row_label_ff   <= row_label_in;
         row_cx2_ff     <= row_cx2_in;
         row_cy2_ff     <= row_cy2_in;
         row_width_ff   <= row_width_in;
         row_height_ff  <= row_height_in;
         row_prior_ff   <= row_prior_in;
      end
      cur_frame_ff  <= cur_frame_in;
      cur_label_ff  <= cur_label_in;
      cur_cx2_ff    <= cur_cx2_in;
      cur_cy2_ff    <= cur_cy2_in;
      cur_width_ff  <= cur_width_in;
      cur_height_ff <= cur_height_in;
      cur_col_ff    <= cur_col_in;
      area_l_ff     <= area_l_in;
      area_r_ff     <= area_r_in;
      geo1_ff       <= geo1_in;
      geo2_ff       <= geo2_in;
      num_ff        <= num_in;
      den_ff        <= den_in;
      ymul_ff       <= ymul_in;
      pos_ff        <= pos_in;
      cosv_ff       <= cosv_in;
      ratio_ff      <= ratio_in;
      sprod_ff      <= sprod_in;
      x_part_ff     <= x_part_in;
      y_part_ff     <= y_part_in;
      s_part_ff     <= s_part_in;
      total_ff      <= total_in;
      rsp_cost_ff   <= rsp_cost_in;
      rsp_col_ff    <= rsp_col_in;
   end

   assign req_stall      = state_ff != S_IDLE;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pair_cost  = rsp_cost_ff;
   assign rsp_out_column = rsp_col_ff;

endmodule

// File: hdl/sbpc_div.sv
`timescale 1ns / 1ps

module sbpc_div (
   input  logic                                clock,
   input  logic                                reset,
   input  sbpc_pkg::div_ctl_type               ctl,
   input  logic [sbpc_pkg::DIV_NUM_W-1:0]      dividend,
   input  logic [sbpc_pkg::DIV_DEN_W-1:0]      divisor,
   output logic [sbpc_pkg::DIV_NUM_W-1:0]      quotient,
   output logic                                done
);
   import sbpc_pkg::*;

   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [DIV_DEN_W:0]   shifted;
   logic [DIV_DEN_W:0]   trial;
   logic                 ge;

   // restoring division, one quotient bit a cycle, dividend arrives msb aligned
   always_comb begin
      shifted = {rem_ff, num_ff[DIV_NUM_W-1]};
      trial   = shifted - {1'b0, den_ff};
      ge      = shifted >= {1'b0, den_ff};
      rem_in  = rem_ff;
      den_in  = den_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         rem_in = '0;
         den_in = divisor;
         num_in = dividend;
         quo_in = '0;
         cnt_in = ctl.count;
      end else if (cnt_ff != '0) begin
         rem_in  = ge ? trial[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
         num_in  = {num_ff[DIV_NUM_W-2:0], 1'b0};
         quo_in  = {quo_ff[DIV_NUM_W-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         done_in = cnt_ff == DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// File: hdl/sbpc_checker.sv
`timescale 1ns / 1ps

module sbpc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_op,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_pair_cost,
   input logic [5:0]  rsp_out_column
);
   import sbpc_pkg::*;

   // a compare request keeps the block busy for the next cycle
   a_compare_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_op == OP_COMPARE) |=> req_stall)
      else $error("compare request not followed by busy");

   // a new response only appears after a compare was in progress
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response without a compare in progress");

   // a load request gives no response
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_op == OP_LOAD) && !rsp_valid |=> !rsp_valid)
      else $error("response after a load request");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pair_cost)
                                 && $stable(rsp_out_column))
      else $error("stalled response changed");

endmodule

bind stereo_box_pair_cost_core sbpc_checker u_sbpc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_op         (req_op),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_pair_cost  (rsp_pair_cost),
   .rsp_out_column (rsp_out_column)
);

// File: verif/sbpc_pair_cost_checker.sv
`timescale 1ns / 1ps

module sbpc_pair_cost_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic              req_op,
   input  logic signed [15:0] req_frame_index,
   input  logic [7:0]        req_class_label,
   input  logic [11:0]       req_box_left,
   input  logic [11:0]       req_box_top,
   input  logic [11:0]       req_box_width,
   input  logic [11:0]       req_box_height,
   input  logic signed [6:0] req_prior_column,
   input  logic [5:0]        req_column,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [31:0]       rsp_pair_cost,
   input  logic [5:0]        rsp_out_column,
   input  logic              csr_write,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_wdata,
   output int                fail_count,
   output int                pending
);
   import sbpc_pkg::*;

   localparam bit [63:0] FULL_COST = 64'(MISMATCH_COST_DEF) << 16;
   localparam bit [63:0] CAP32     = 64'hFFFF_FFFF;

   typedef struct packed {
      logic [31:0] cost;
      logic [5:0]  col;
   } pair_cost_type;

   pair_cost_type expected_costs[$];

   bit [16:0] cos_q16[17] = '{65536, 65220, 64277, 62714, 60547, 57798, 54491, 50660,
                              46341, 41576, 36410, 30893, 25080, 19024, 12785, 6424, 0};

   // configuration copy
   logic signed [12:0] y_off;
   bit [15:0] w_x, w_y, w_size, lim_size, penalty;
   bit [11:0] lim_x, lim_y;

   // stored left box
   logic signed [15:0] row_frame;
   bit [7:0]  row_label;
   bit [13:0] row_cx2, row_cy2;
   bit [11:0] row_w, row_h;
   logic signed [6:0] row_prior;

   function automatic bit [63:0] x_cost(longint d);
      bit [63:0] lim2, p, idx, frac, c;
      if (d < 0) return FULL_COST;
      if (lim_x == 0) return 64'(w_x) << 8;
      lim2 = 2 * 64'(lim_x);
      if (64'(d) >= lim2) return 0;
      p = (64'(d) << 16) / lim2;
      idx = (p >> 12) & 15;
      frac = p & 64'hFFF;
      c = cos_q16[idx] - (((64'(cos_q16[idx]) - cos_q16[idx+1]) * frac) >> 12);
      return (64'(w_x) * c) >> 8;
   endfunction

   function automatic bit [63:0] y_cost(longint g);
      bit [63:0] lim2, ag;
      lim2 = 2 * 64'(lim_y);
      ag = (g < 0) ? 64'(-g) : 64'(g);
      if (w_y == 0 || ag >= lim2) return FULL_COST;
      return (64'(w_y) * ag * 256) / lim2;
   endfunction

   function automatic bit [63:0] size_cost(bit [63:0] wl, hl, wr, hr);
      bit [63:0] a, b, g1, g2, n, dd, q, rem, r, part;
      a = wl * hl;
      b = wr * hr;
      if (a == 0 || b == 0 || lim_size <= 256) return FULL_COST;
      g1 = (hl > 0 ? hl : 1) * (wr > 0 ? wr : 1);
      g2 = (wl > 0 ? wl : 1) * (hr > 0 ? hr : 1);
      n  = (a > b ? a : b) * (g1 > g2 ? g1 : g2);
      dd = (a < b ? a : b) * (g1 < g2 ? g1 : g2);
      q = (n - dd) / dd;
      rem = (n - dd) % dd;
      if (q >= (64'd1 << 32)) r = 64'd1 << 48;
      else r = (q << 16) + ((rem << 16) / dd);
      if (r > (64'd1 << 48)) r = 64'd1 << 48;
      part = (64'(w_size) * r) / 64'(lim_size - 16'd256);
      return part > CAP32 ? CAP32 : part;
   endfunction

   function automatic pair_cost_type predict_cost(logic signed [15:0] frame, bit [7:0] label,
                                                  bit [11:0] l, t, w, h, bit [5:0] col);
      pair_cost_type res;
      bit [63:0] total;
      longint cx2, cy2;
      cx2 = 2 * longint'(l) + longint'(w);
      cy2 = 2 * longint'(t) + longint'(h);
      total = x_cost(longint'(row_cx2) - cx2);
      total += y_cost(longint'(row_cy2) - cy2 + 2 * longint'(y_off));
      total += size_cost(row_w, row_h, w, h);
      total += (row_frame == frame && row_frame > 0) ? 0 : FULL_COST;
      total += (row_label == label) ? 0 : FULL_COST;
      if (total > CAP32) total = CAP32;
      if (row_prior != -1 && int'(row_prior) != int'(col)) begin
         total = (total * 64'(penalty)) >> 8;
         if (total > CAP32) total = CAP32;
      end
      res.cost = total[31:0];
      res.col = col;
      return res;
   endfunction

   always @(posedge clock) begin
      pair_cost_type exp_item;
      if (reset) begin
         y_off = 0; w_x = 256; w_y = 256; w_size = 256;
         lim_x = 256; lim_y = 16; lim_size = 512; penalty = 512;
         row_frame = -1; row_label = 0; row_cx2 = 0; row_cy2 = 0;
         row_w = 0; row_h = 0; row_prior = -1;
         expected_costs.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_Y_OFFSET:    y_off = csr_wdata[12:0];
               REG_WEIGHT_X:    w_x = csr_wdata;
               REG_WEIGHT_Y:    w_y = csr_wdata;
               REG_WEIGHT_SIZE: w_size = csr_wdata;
               REG_LIMIT_X:     lim_x = csr_wdata[11:0];
               REG_LIMIT_Y:     lim_y = csr_wdata[11:0];
               REG_LIMIT_SIZE:  lim_size = csr_wdata;
               REG_PENALTY:     penalty = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_costs.size() == 0) begin
               $error("response with no request waiting: cost %0h column %0d",
                      rsp_pair_cost, rsp_out_column);
               fail_count++;
            end else begin
               exp_item = expected_costs.pop_front();
               if (rsp_pair_cost !== exp_item.cost) begin
                  $error("pair_cost expected %0h actual %0h", exp_item.cost, rsp_pair_cost);
                  fail_count++;
               end
               if (rsp_out_column !== exp_item.col) begin
                  $error("out_column expected %0d actual %0d", exp_item.col, rsp_out_column);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_op == OP_LOAD) begin
               row_frame = req_frame_index;
               row_label = req_class_label;
               row_cx2 = 14'(2 * int'(req_box_left) + int'(req_box_width));
               row_cy2 = 14'(2 * int'(req_box_top) + int'(req_box_height));
               row_w = req_box_width;
               row_h = req_box_height;
               row_prior = req_prior_column;
            end else begin
               expected_costs = {expected_costs, predict_cost(req_frame_index,
                  req_class_label, req_box_left, req_box_top, req_box_width,
                  req_box_height, req_column)};
            end
         end
      end
      pending = expected_costs.size();
   end

endmodule

// File: verif/stereo_box_pair_cost_core_tb.sv
`timescale 1ns / 1ps

module stereo_box_pair_cost_core_tb;
   import sbpc_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic req_op = OP_LOAD;
   logic signed [15:0] req_frame_index = 0;
   logic [7:0]  req_class_label = 0;
   logic [11:0] req_box_left = 0, req_box_top = 0, req_box_width = 0, req_box_height = 0;
   logic signed [6:0] req_prior_column = 0;
   logic [5:0]  req_column = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [31:0] rsp_pair_cost;
   logic [5:0]  rsp_out_column;
   logic        csr_write = 0;
   logic [2:0]  csr_index = REG_Y_OFFSET;
   logic [15:0] csr_wdata = 0;

   int fail_count, pending;
   int cycles = 0;
   int n_loads = 0, n_compares = 0;
   bit steady = 0;

   // left box of the current row, kept for building near matches
   int row_l, row_t, row_w, row_h, row_frame, row_label;

   stereo_box_pair_cost_core dut (.*);

   sbpc_pair_cost_checker checker_i (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_stall <= !steady && ($urandom_range(99) < 33);

   task automatic send_request(logic op, int frame, int label, int l, int t, int w, int h,
                               int prior, int col);
      bit accepted;
      while (!steady && $urandom_range(99) < 33) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_op <= op;
      req_frame_index <= frame[15:0];
      req_class_label <= label[7:0];
      req_box_left <= l[11:0];
      req_box_top <= t[11:0];
      req_box_width <= w[11:0];
      req_box_height <= h[11:0];
      req_prior_column <= prior[6:0];
      req_column <= col[5:0];
      // stall only changes at the rising edge, so its value now decides the next edge
      accepted = 0;
      while (!accepted) begin
         accepted = !req_stall;
         @(negedge clock);
      end
      if (op == OP_LOAD) n_loads++;
      else n_compares++;
   endtask

   task automatic load_row(int frame, int label, int l, int t, int w, int h, int prior);
      row_frame = frame; row_label = label;
      row_l = l; row_t = t; row_w = w; row_h = h;
      send_request(OP_LOAD, frame, label, l, t, w, h, prior, $urandom_range(63));
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      while (pending != 0) @(negedge clock);
      // a load gives no response, so leave the core time to settle
      repeat (300) @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, int value);
      csr_write <= 1;
      csr_index <= idx;
      csr_wdata <= value[15:0];
      @(negedge clock);
      csr_write <= 0;
   endtask

   task automatic write_all(int yo, int wx, int wy, int ws, int lx, int ly, int ls, int pen);
      write_reg(REG_Y_OFFSET, yo);
      write_reg(REG_WEIGHT_X, wx);
      write_reg(REG_WEIGHT_Y, wy);
      write_reg(REG_WEIGHT_SIZE, ws);
      write_reg(REG_LIMIT_X, lx);
      write_reg(REG_LIMIT_Y, ly);
      write_reg(REG_LIMIT_SIZE, ls);
      write_reg(REG_PENALTY, pen);
   endtask

   function automatic int clip12(int v);
      return v < 0 ? 0 : (v > 4095 ? 4095 : v);
   endfunction

   // right box close to the stored left box, mostly a plausible match
   task automatic compare_near();
      int l, t, w, h, frame, label;
      l = clip12(row_l - int'($urandom_range(300)) + 20);
      t = clip12(row_t + int'($urandom_range(40)) - 20);
      w = clip12(row_w + int'($urandom_range(row_w / 4 + 2)) - row_w / 8);
      h = clip12(row_h + int'($urandom_range(row_h / 4 + 2)) - row_h / 8);
      frame = ($urandom_range(9) == 0) ? int'($urandom_range(32767)) : row_frame;
      label = ($urandom_range(9) == 0) ? int'($urandom_range(255)) : row_label;
      send_request(OP_COMPARE, frame, label, l, t, w, h, $urandom_range(127),
                   $urandom_range(63));
   endtask

   task automatic random_noise();
      send_request(1'($urandom_range(1)), $urandom_range(65535), $urandom_range(255),
                   $urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                   $urandom_range(4095), $urandom_range(127), $urandom_range(63));
   endtask

   initial begin
      int phase, items;
      repeat (9) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // compare before any load sees the empty row
      send_request(OP_COMPARE, 5, 3, 100, 100, 50, 50, 0, 1);
      load_row(5, 3, 1000, 500, 100, 80, -1);
      send_request(OP_COMPARE, 5, 3, 1000, 500, 100, 80, 0, 0);
      send_request(OP_COMPARE, 5, 3, 950, 500, 100, 80, 0, 1);
      send_request(OP_COMPARE, 5, 3, 1100, 500, 100, 80, 0, 2);
      send_request(OP_COMPARE, 5, 4, 990, 500, 100, 80, 0, 3);
      send_request(OP_COMPARE, 6, 3, 990, 500, 100, 80, 0, 4);
      send_request(OP_COMPARE, 5, 3, 990, 500, 0, 80, 0, 5);
      send_request(OP_COMPARE, 5, 3, 990, 3000, 100, 80, 0, 6);
      load_row(9, 7, 2000, 1000, 300, 200, 7);
      send_request(OP_COMPARE, 9, 7, 1900, 1002, 280, 210, -1, 7);
      send_request(OP_COMPARE, 9, 7, 1900, 1002, 280, 210, 63, 8);
      load_row(9, 7, 2000, 1000, 300, 200, -64);
      send_request(OP_COMPARE, 9, 7, 1990, 1000, 300, 200, 0, 0);
      load_row(32767, 255, 4095, 4095, 4095, 4095, 63);
      send_request(OP_COMPARE, 32767, 255, 4095, 4095, 4095, 4095, 0, 63);
      send_request(OP_COMPARE, 0, 0, 0, 0, 0, 0, 0, 0);
      send_request(OP_COMPARE, -1, 255, 0, 4095, 1, 4095, 0, 62);
      load_row(0, 0, 0, 0, 0, 0, -1);
      send_request(OP_COMPARE, 0, 0, 0, 0, 0, 0, 0, 0);
      load_row(-1, 1, 10, 10, 1, 4095, 0);
      send_request(OP_COMPARE, -1, 1, 5, 10, 4095, 1, 0, 0);
      wait_drained();

      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: write_all(-4096, 0, 65535, 0, 0, 4095, 256, 0);
            1: write_all(4095, 65535, 1, 65535, 1, 1, 257, 65535);
            2: write_all(0, 256, 256, 256, 4095, 0, 65535, 256);
            default: write_all($urandom_range(8191), $urandom_range(65535),
                               $urandom_range(65535), $urandom_range(65535),
                               $urandom_range(4095), $urandom_range(4095),
                               $urandom_range(65535), $urandom_range(65535));
         endcase
         steady = (phase == 3);
         items = 0;
         while (items < 300) begin
            if ($urandom_range(99) < 15) begin
               random_noise();
               items++;
            end else begin
               load_row($urandom_range(32767), $urandom_range(255), $urandom_range(4095),
                        $urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                        $urandom_range(3) == 0 ? -1 : int'($urandom_range(63)));
               items++;
               repeat ($urandom_range(8, 1)) begin
                  compare_near();
                  items++;
               end
            end
         end
         steady = 0;
         wait_drained();
      end

      $display("covered %0d loads and %0d compares over 7 register settings",
               n_loads, n_compares);
      if (fail_count == 0 && pending == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
